// ----- rtl/tpq_pkg.sv -----
package tpq_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF    = 64;
   localparam int HANDLE_BITS_DEF = 32;

   // Fixed field widths of the request and response words
   localparam int KIND_W     = 3;
   localparam int DEADLINE_W = 63;
   localparam int ID_W       = 64;
   localparam int FIELD_W    = 32;
   localparam int STATUS_W   = 2;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POP       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CANCEL_MT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CANCEL_ID = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd5;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [DEADLINE_W-1:0] deadline;
      logic [FIELD_W-1:0]    callback_ref;
      logic [FIELD_W-1:0]    user_ref;
      logic [ID_W-1:0]       cancel_id;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [ID_W-1:0]       assigned_id;
      logic [DEADLINE_W-1:0] out_deadline;
      logic [FIELD_W-1:0]    out_callback;
      logic [FIELD_W-1:0]    out_user;
      logic                  now_empty;
   } rsp_word_type;

endpackage

// ----- rtl/timer_priority_queue.sv -----
// Timer priority queue: a table of up to CAPACITY pending reminders, each a
// (deadline, callback, user) triple plus an id from a counter starting at 1.
// Earliest = smallest deadline, ties broken by smaller id.
//
// Request side: a word on req_word is taken at a clock edge where start is
// high and busy is low. busy stays high until the response is produced.
// Response side: rsp_word is valid for exactly one cycle while rsp_strobe is
// high. There is no back-pressure; the receiver must take it.
//
// Every operation does one full scan of the entry RAM (one entry per cycle,
// one read port), then a drain state and a commit state. rsp_strobe is
// registered from the commit state; a new start is taken in the strobe cycle,
// so the block takes no new word until the last one has been answered. The
// scan length is set by the single read port of the entry RAM.
//
// Reset (synchronous, active high) empties the queue and sets the next id to
// 1. Entry RAM contents are not cleared; per-entry valid bits guard them.
module timer_priority_queue #(
   parameter int CAPACITY    = tpq_pkg::CAPACITY_DEF,
   parameter int HANDLE_BITS = tpq_pkg::HANDLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tpq_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output tpq_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int DEADLINE_W = tpq_pkg::DEADLINE_W;
   localparam int ID_W       = tpq_pkg::ID_W;
   localparam int FIELD_W    = tpq_pkg::FIELD_W;
   // entry layout: {deadline, id, callback, user}
   localparam int US_LSB     = 0;
   localparam int CB_LSB     = HANDLE_BITS;
   localparam int ID_LSB     = 2 * HANDLE_BITS;
   localparam int DL_LSB     = ID_LSB + ID_W;
   localparam int ENTRY_W    = DL_LSB + DEADLINE_W;

   // control state
   tpq_pkg::state_type    state_ff, state_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  pipe_en_ff, pipe_en_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  free_found_ff, free_found_in;
   logic                  trip_found_ff, trip_found_in;
   logic                  idm_found_ff, idm_found_in;
   logic                  best_found_ff, best_found_in;

   // payload
   tpq_pkg::req_word_type req_ff, req_in;
   tpq_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                  pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]      pipe_idx_ff, pipe_idx_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]      trip_idx_ff, trip_idx_in;
   logic [IDX_W-1:0]      idm_idx_ff, idm_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [DEADLINE_W-1:0] best_dl_ff, best_dl_in;
   logic [ID_W-1:0]       best_id_ff, best_id_in;
   logic [HANDLE_BITS-1:0] best_cb_ff, best_cb_in;
   logic [HANDLE_BITS-1:0] best_us_ff, best_us_in;

   // entry RAM
   logic                  ram_we;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic [ENTRY_W-1:0]    ram_rd_data;

   // request handles reduced to the stored width
   logic [HANDLE_BITS-1:0] req_cb;
   logic [HANDLE_BITS-1:0] req_us;

   // fields of the entry coming out of the RAM
   logic [DEADLINE_W-1:0]  e_dl;
   logic [ID_W-1:0]        e_id;
   logic [HANDLE_BITS-1:0] e_cb;
   logic [HANDLE_BITS-1:0] e_us;
   logic                   trip_hit;
   logic                   id_hit;
   logic                   earlier;

   assign req_cb = HANDLE_BITS'(req_ff.callback_ref);
   assign req_us = HANDLE_BITS'(req_ff.user_ref);

   assign e_dl = ram_rd_data[DL_LSB +: DEADLINE_W];
   assign e_id = ram_rd_data[ID_LSB +: ID_W];
   assign e_cb = ram_rd_data[CB_LSB +: HANDLE_BITS];
   assign e_us = ram_rd_data[US_LSB +: HANDLE_BITS];

   // shared compare unit: one entry per cycle
   assign trip_hit = (e_dl == req_ff.deadline) && (e_cb == req_cb) && (e_us == req_us);
   assign id_hit   = (e_id == req_ff.cancel_id);
   assign earlier  = {e_dl, e_id} < {best_dl_ff, best_id_ff};

   assign ram_wr_data = {req_ff.deadline, next_id_ff, req_cb, req_us};

   tpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      pipe_en_in    = 1'b0;
      pipe_vld_in   = pipe_vld_ff;
      pipe_idx_in   = pipe_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      req_in        = req_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      trip_found_in = trip_found_ff;
      trip_idx_in   = trip_idx_ff;
      idm_found_in  = idm_found_ff;
      idm_idx_in    = idm_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_id_in    = best_id_ff;
      best_cb_in    = best_cb_ff;
      best_us_in    = best_us_ff;
      ram_we        = 1'b0;

      // compare stage, working in the cycle after its RAM address
      if (pipe_en_ff && pipe_vld_ff) begin
         if (!trip_found_ff && trip_hit) begin
            trip_found_in = 1'b1;
            trip_idx_in   = pipe_idx_ff;
         end
         if (!idm_found_ff && id_hit) begin
            idm_found_in = 1'b1;
            idm_idx_in   = pipe_idx_ff;
         end
         if (!best_found_ff || earlier) begin
            best_found_in = 1'b1;
            best_idx_in   = pipe_idx_ff;
            best_dl_in    = e_dl;
            best_id_in    = e_id;
            best_cb_in    = e_cb;
            best_us_in    = e_us;
         end
      end

      unique case (state_ff)
         tpq_pkg::ST_IDLE: begin
            if (start) begin
               req_in        = req_word;
               scan_idx_in   = '0;
               free_found_in = 1'b0;
               trip_found_in = 1'b0;
               idm_found_in  = 1'b0;
               best_found_in = 1'b0;
               state_in      = tpq_pkg::ST_SCAN;
            end
         end
         tpq_pkg::ST_SCAN: begin
            pipe_en_in  = 1'b1;
            pipe_vld_in = valid_ff[scan_idx_ff];
            pipe_idx_in = scan_idx_ff;
            // lowest free slot
            if (!free_found_ff && !valid_ff[scan_idx_ff]) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
            end
            if (scan_idx_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = tpq_pkg::ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         tpq_pkg::ST_DRAIN: begin
            state_in = tpq_pkg::ST_COMMIT;
         end
         tpq_pkg::ST_COMMIT: begin
            rsp_in        = '0;
            rsp_in.status = tpq_pkg::STATUS_OK;
            unique case (req_ff.kind) inside
               tpq_pkg::KIND_PUSH: begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_in.status = tpq_pkg::STATUS_FULL;
                  end else if (trip_found_ff) begin
                     // duplicate still burns an id
                     rsp_in.status = tpq_pkg::STATUS_DUPLICATE;
                     next_id_in    = next_id_ff + ID_W'(1);
                  end else begin
                     ram_we                = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     count_in              = count_ff + CNT_W'(1);
                     rsp_in.assigned_id    = next_id_ff;
                     next_id_in            = next_id_ff + ID_W'(1);
                  end
               end
               tpq_pkg::KIND_POP, tpq_pkg::KIND_PEEK: begin
                  if (!best_found_ff) begin
                     rsp_in.status = tpq_pkg::STATUS_NOT_FOUND;
                  end else begin
                     rsp_in.assigned_id  = best_id_ff;
                     rsp_in.out_deadline = best_dl_ff;
                     rsp_in.out_callback = FIELD_W'(best_cb_ff);
                     rsp_in.out_user     = FIELD_W'(best_us_ff);
                     if (req_ff.kind == tpq_pkg::KIND_POP) begin
                        valid_in[best_idx_ff] = 1'b0;
                        count_in              = count_ff - CNT_W'(1);
                     end
                  end
               end
               tpq_pkg::KIND_CANCEL_MT: begin
                  if (!trip_found_ff) begin
                     rsp_in.status = tpq_pkg::STATUS_NOT_FOUND;
                  end else begin
                     valid_in[trip_idx_ff] = 1'b0;
                     count_in              = count_ff - CNT_W'(1);
                  end
               end
               tpq_pkg::KIND_CANCEL_ID: begin
                  if (!idm_found_ff) begin
                     rsp_in.status = tpq_pkg::STATUS_NOT_FOUND;
                  end else begin
                     valid_in[idm_idx_ff] = 1'b0;
                     count_in             = count_ff - CNT_W'(1);
                  end
               end
               tpq_pkg::KIND_CLEAR: begin
                  valid_in = '0;
                  count_in = '0;
               end
               default: begin
                  // unused codes: no operation
               end
            endcase
            rsp_in.now_empty = (count_in == '0);
            rsp_strobe_in    = 1'b1;
            state_in         = tpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = tpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tpq_pkg::ST_IDLE;
         scan_idx_ff   <= '0;
         pipe_en_ff    <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         next_id_ff    <= ID_W'(1);
         rsp_strobe_ff <= 1'b0;
         free_found_ff <= 1'b0;
         trip_found_ff <= 1'b0;
         idm_found_ff  <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         pipe_en_ff    <= pipe_en_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         next_id_ff    <= next_id_in;
         rsp_strobe_ff <= rsp_strobe_in;
         free_found_ff <= free_found_in;
         trip_found_ff <= trip_found_in;
         idm_found_ff  <= idm_found_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      pipe_vld_ff <= pipe_vld_in;
      pipe_idx_ff <= pipe_idx_in;
      free_idx_ff <= free_idx_in;
      trip_idx_ff <= trip_idx_in;
      idm_idx_ff  <= idm_idx_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      best_id_ff  <= best_id_in;
      best_cb_ff  <= best_cb_in;
      best_us_ff  <= best_us_in;
   end

   assign busy       = (state_ff != tpq_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

`ifndef NO_ASSERTIONS
   // occupancy counter tracks the valid bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("entry count out of step with valid bits");

   // a response only follows the commit cycle
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == tpq_pkg::ST_COMMIT))
      else $error("response strobe without commit");

   // an accepted word makes the block busy on the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start a scan");

   // empty flag agrees with the occupancy it reports
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (rsp_ff.now_empty == (count_ff == '0)))
      else $error("now_empty disagrees with occupancy");

   // the table never goes past capacity
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");
`endif

endmodule

// ----- rtl/tpq_ram.sv -----
// Simple dual-port RAM, registered read.
module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/timer_priority_queue_test.sv -----
module timer_priority_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tpq_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEF;
   localparam int HANDLE_BITS = HANDLE_BITS_DEF;

   // Handles are kept modulo 2^HANDLE_BITS inside the block
   localparam logic [63:0] HANDLE_MASK =
      (HANDLE_BITS >= 64) ? '1 : (64'd1 << HANDLE_BITS) - 64'd1;

   // Kinds 6 and 7 are decoded as no-ops
   localparam logic [KIND_W-1:0] KIND_NOP_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_NOP_HI = 3'd7;

   localparam int RANDOM_WORDS    = 2000;
   localparam int QUIET_TAIL      = 150;   // last words go back to back
   localparam int MAX_ERROR_LINES = 40;
   // Slowest legal run is about 1.8 ms
   localparam int LIMIT_NS        = 10_000_000;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_BALANCED
   } op_mix_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         start      = 1'b0;
   req_word_type req_word   = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   timer_priority_queue #(
      .CAPACITY    (CAPACITY),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // ------------------------------------------------------------------
   // Shadow copy of the reminder table
   // ------------------------------------------------------------------
   logic [DEADLINE_W-1:0] shadow_deadline [CAPACITY];
   logic [ID_W-1:0]       shadow_id       [CAPACITY];
   logic [FIELD_W-1:0]    shadow_callback [CAPACITY];
   logic [FIELD_W-1:0]    shadow_user     [CAPACITY];
   bit                    shadow_valid    [CAPACITY];
   logic [ID_W-1:0]       shadow_next_id;

   req_word_type timer_ops[$];       // words still to be sent
   rsp_word_type owed_rsp[$];        // responses the block still owes us

   int error_count   = 0;
   int checked_count = 0;
   int kind_count   [8];
   int status_count [4];

   // Idle burst control for the request side
   int idle_left    = 0;
   bit idle_stretch = 1'b1;

   // Generator bookkeeping: recently pushed triples and a rough id count
   req_word_type recent_triples[$];
   logic [ID_W-1:0] ids_issued = '0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic int find_reminder(logic [DEADLINE_W-1:0] dl,
                                        logic [FIELD_W-1:0] cb,
                                        logic [FIELD_W-1:0] us);
      for (int i = 0; i < CAPACITY; i++) begin
         if (shadow_valid[i] && shadow_deadline[i] == dl &&
             shadow_callback[i] == cb && shadow_user[i] == us)
            return i;
      end
      return -1;
   endfunction

   // Applies one operation to the shadow table, returns the response word
   function automatic rsp_word_type apply_timer_op(req_word_type w);
      rsp_word_type       r;
      int                 slot;
      logic [FIELD_W-1:0] cb;
      logic [FIELD_W-1:0] us;
      r    = '0;
      slot = -1;
      cb   = w.callback_ref & HANDLE_MASK[FIELD_W-1:0];
      us   = w.user_ref & HANDLE_MASK[FIELD_W-1:0];
      case (w.kind)
         KIND_PUSH: begin
            for (int i = CAPACITY - 1; i >= 0; i--)
               if (!shadow_valid[i]) slot = i;
            // full is checked before duplicate; a duplicate still burns an id
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else if (find_reminder(w.deadline, cb, us) >= 0) begin
               r.status = STATUS_DUPLICATE;
               shadow_next_id++;
            end else begin
               shadow_deadline[slot] = w.deadline;
               shadow_callback[slot] = cb;
               shadow_user[slot]     = us;
               shadow_id[slot]       = shadow_next_id;
               shadow_valid[slot]    = 1'b1;
               r.assigned_id         = shadow_next_id;
               shadow_next_id++;
            end
         end
         KIND_POP, KIND_PEEK: begin
            // earliest deadline, ties go to the smaller id
            for (int i = 0; i < CAPACITY; i++) begin
               if (shadow_valid[i] &&
                   (slot < 0 || shadow_deadline[i] < shadow_deadline[slot] ||
                    (shadow_deadline[i] == shadow_deadline[slot] &&
                     shadow_id[i] < shadow_id[slot])))
                  slot = i;
            end
            if (slot < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               r.assigned_id  = shadow_id[slot];
               r.out_deadline = shadow_deadline[slot];
               r.out_callback = shadow_callback[slot];
               r.out_user     = shadow_user[slot];
               if (w.kind == KIND_POP) shadow_valid[slot] = 1'b0;
            end
         end
         KIND_CANCEL_MT: begin
            slot = find_reminder(w.deadline, cb, us);
            if (slot < 0) r.status = STATUS_NOT_FOUND;
            else shadow_valid[slot] = 1'b0;
         end
         KIND_CANCEL_ID: begin
            for (int i = CAPACITY - 1; i >= 0; i--)
               if (shadow_valid[i] && shadow_id[i] == w.cancel_id) slot = i;
            if (slot < 0) r.status = STATUS_NOT_FOUND;
            else shadow_valid[slot] = 1'b0;
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CAPACITY; i++) shadow_valid[i] = 1'b0;
         end
         default: begin
         end
      endcase
      r.now_empty = 1'b1;
      for (int i = 0; i < CAPACITY; i++)
         if (shadow_valid[i]) r.now_empty = 1'b0;
      return r;
   endfunction

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_ERROR_LINES)
         $display("[%0t] ERROR: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Small deadlines dominate so that ties on deadline show up often
   function automatic logic [DEADLINE_W-1:0] random_deadline();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return DEADLINE_W'($urandom_range(0, 31));
         6, 7:       return DEADLINE_W'($urandom);
         default:    return DEADLINE_W'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] random_handle();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return FIELD_W'($urandom_range(0, 7));
         default:    return FIELD_W'($urandom);
      endcase
   endfunction

   // Mostly ids near the ones recently handed out, so cancels hit
   function automatic logic [ID_W-1:0] random_cancel_id();
      logic [ID_W-1:0] lo;
      lo = (ids_issued > 80) ? ids_issued - 64'd80 : '0;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return {$urandom, $urandom};
         default: return lo + ID_W'($urandom_range(0, 84));
      endcase
   endfunction

   task automatic queue_word(logic [KIND_W-1:0] kind, logic [DEADLINE_W-1:0] dl,
                             logic [FIELD_W-1:0] cb, logic [FIELD_W-1:0] us,
                             logic [ID_W-1:0] cid);
      req_word_type w;
      w.kind         = kind;
      w.deadline     = dl;
      w.callback_ref = cb;
      w.user_ref     = us;
      w.cancel_id    = cid;
      timer_ops.push_back(w);
      if (kind == KIND_PUSH) begin
         ids_issued++;
         recent_triples.push_back(w);
         if (recent_triples.size() > 96) void'(recent_triples.pop_front());
      end
   endtask

   // One random word; no-op kinds do not count toward the word budget
   task automatic queue_random_word(op_mix_type mix, output bit counted);
      int                    roll;
      int                    push_w, pop_w, peek_w, cmt_w, cid_w, clear_w;
      logic [KIND_W-1:0]     kind;
      logic [DEADLINE_W-1:0] dl;
      logic [FIELD_W-1:0]    cb;
      logic [FIELD_W-1:0]    us;
      req_word_type          old;
      case (mix)
         MIX_FILL:  begin
            push_w = 76; pop_w = 5; peek_w = 5; cmt_w = 5; cid_w = 5; clear_w = 0;
         end
         MIX_DRAIN: begin
            push_w = 22; pop_w = 28; peek_w = 10; cmt_w = 15; cid_w = 20; clear_w = 1;
         end
         default:   begin
            push_w = 42; pop_w = 18; peek_w = 10; cmt_w = 12; cid_w = 13; clear_w = 2;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_w)
         kind = KIND_PUSH;
      else if (roll < push_w + pop_w)
         kind = KIND_POP;
      else if (roll < push_w + pop_w + peek_w)
         kind = KIND_PEEK;
      else if (roll < push_w + pop_w + peek_w + cmt_w)
         kind = KIND_CANCEL_MT;
      else if (roll < push_w + pop_w + peek_w + cmt_w + cid_w)
         kind = KIND_CANCEL_ID;
      else if (roll < push_w + pop_w + peek_w + cmt_w + cid_w + clear_w)
         kind = KIND_CLEAR;
      else
         kind = $urandom_range(0, 1) ? KIND_NOP_HI : KIND_NOP_LO;

      // unused fields carry random junk too
      dl = random_deadline();
      cb = random_handle();
      us = random_handle();
      // reuse a known triple: duplicate pushes, matching cancels
      if (recent_triples.size() != 0 &&
          ((kind == KIND_PUSH && $urandom_range(0, 3) == 0) ||
           (kind == KIND_CANCEL_MT && $urandom_range(0, 3) != 0))) begin
         old = recent_triples[$urandom_range(0, recent_triples.size() - 1)];
         dl  = old.deadline;
         cb  = old.callback_ref;
         us  = old.user_ref;
      end
      queue_word(kind, dl, cb, us, random_cancel_id());
      counted = (kind != KIND_NOP_LO && kind != KIND_NOP_HI);
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Request driver: a word is taken when start is high and busy is low.
   // start only drops when the word was taken or an idle burst runs.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_words
      bit taken;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            owed_rsp.push_back(apply_timer_op(req_word));
            kind_count[req_word.kind]++;
         end
         if (!start || taken) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (timer_ops.size() != 0) begin
               req_word <= timer_ops.pop_front();
               start    <= 1'b1;
               // alternate stretches with and without gaps; none near the end
               if ($urandom_range(0, 39) == 0) idle_stretch = !idle_stretch;
               if (idle_stretch && timer_ops.size() > QUIET_TAIL &&
                   $urandom_range(0, 2) == 0)
                  idle_left = $urandom_range(1, 18);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: a word is on rsp_word for exactly one strobe cycle
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (owed_rsp.size() == 0) begin
            report_error("response word with no request outstanding");
         end else begin
            want = owed_rsp.pop_front();
            checked_count++;
            status_count[want.status]++;
            if (rsp_word.status !== want.status)
               report_error($sformatf("rsp %0d status got %0d want %0d",
                  checked_count, rsp_word.status, want.status));
            if (rsp_word.assigned_id !== want.assigned_id)
               report_error($sformatf("rsp %0d assigned_id got %0h want %0h",
                  checked_count, rsp_word.assigned_id, want.assigned_id));
            if (rsp_word.out_deadline !== want.out_deadline)
               report_error($sformatf("rsp %0d out_deadline got %0h want %0h",
                  checked_count, rsp_word.out_deadline, want.out_deadline));
            if (rsp_word.out_callback !== want.out_callback)
               report_error($sformatf("rsp %0d out_callback got %0h want %0h",
                  checked_count, rsp_word.out_callback, want.out_callback));
            if (rsp_word.out_user !== want.out_user)
               report_error($sformatf("rsp %0d out_user got %0h want %0h",
                  checked_count, rsp_word.out_user, want.out_user));
            if (rsp_word.now_empty !== want.now_empty)
               report_error($sformatf("rsp %0d now_empty got %0b want %0b",
                  checked_count, rsp_word.now_empty, want.now_empty));
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      op_mix_type mix;
      int         counted;
      int         seg_left;
      bit         counted_one;

      for (int i = 0; i < CAPACITY; i++) shadow_valid[i] = 1'b0;
      shadow_next_id = 64'd1;

      // Directed: empty-queue misses, field extremes, duplicate, ties,
      // cancels both ways, no-op kinds, clear on empty and on a loaded table
      queue_word(KIND_POP,       '0, '0, '0, '0);
      queue_word(KIND_PEEK,      '0, '0, '0, '0);
      queue_word(KIND_CANCEL_MT, '0, '0, '0, '0);
      queue_word(KIND_CANCEL_ID, '0, '0, '0, '0);
      queue_word(KIND_PUSH,      '1, '1, '1, '0);
      queue_word(KIND_PUSH,      '0, '0, '0, '1);
      queue_word(KIND_PUSH,      '0, '0, '0, '0);   // duplicate, burns an id
      queue_word(KIND_PUSH,      '0, 32'd1, '0, '0); // same deadline, later id
      queue_word(KIND_PEEK,      '1, '1, '1, '1);
      queue_word(KIND_CANCEL_ID, '0, '0, '0, '1);   // no such id
      queue_word(KIND_CANCEL_ID, '0, '0, '0, 64'd4);
      queue_word(KIND_CANCEL_MT, '1, '1, '1, '0);
      queue_word(KIND_CANCEL_MT, '1, '1, '1, '0);   // already gone
      queue_word(KIND_NOP_LO,    '1, '1, '1, '1);
      queue_word(KIND_NOP_HI,    '1, '1, '1, '1);
      queue_word(KIND_POP,       '0, '0, '0, '0);
      queue_word(KIND_POP,       '0, '0, '0, '0);   // empty again
      queue_word(KIND_CLEAR,     '0, '0, '0, '0);
      queue_word(KIND_PUSH,      63'd5, 32'd7, 32'd9, '0);
      queue_word(KIND_PUSH,      63'd5, 32'd7, 32'd8, '0);
      queue_word(KIND_CLEAR,     '0, '0, '0, '0);
      queue_word(KIND_PUSH,      63'd5, 32'd7, 32'd9, '0); // no dup after clear
      queue_word(KIND_CANCEL_ID, '0, '0, '0, 64'd7);
      queue_word(KIND_PEEK,      '0, '0, '0, '0);

      // Random: segments of fill / drain / balanced traffic. The first
      // segment fills the table so the full case is reached early.
      counted  = 0;
      mix      = MIX_FILL;
      seg_left = 100;
      while (counted < RANDOM_WORDS) begin
         if (seg_left == 0) begin
            mix      = op_mix_type'($urandom_range(0, 2));
            seg_left = $urandom_range(20, 120);
         end
         queue_random_word(mix, counted_one);
         counted += counted_one;
         seg_left--;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // all words sent and taken, then all responses in
      while (timer_ops.size() != 0 || start) @(negedge clock);
      while (owed_rsp.size() != 0) @(negedge clock);
      // room for a stray response: one full scan plus commit
      repeat (CAPACITY + 8) @(negedge clock);

      $display("Sent %0d push, %0d pop, %0d peek, %0d cancel-match, %0d cancel-id, %0d clear, %0d no-op",
         kind_count[KIND_PUSH], kind_count[KIND_POP], kind_count[KIND_PEEK],
         kind_count[KIND_CANCEL_MT], kind_count[KIND_CANCEL_ID],
         kind_count[KIND_CLEAR], kind_count[KIND_NOP_LO] + kind_count[KIND_NOP_HI]);
      $display("Checked %0d responses: %0d ok, %0d duplicate, %0d full, %0d not found, %0d errors",
         checked_count, status_count[STATUS_OK], status_count[STATUS_DUPLICATE],
         status_count[STATUS_FULL], status_count[STATUS_NOT_FOUND], error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_NS);
      $display("Timeout with %0d words unsent, %0d responses owed",
         timer_ops.size(), owed_rsp.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tpq_pkg.sv
rtl/tpq_ram.sv
rtl/timer_priority_queue.sv
bench/timer_priority_queue_test.sv
